// File: sv/history_run_pixel_decoder_core_assert.svh
// Assertion macros used by the decoder RTL (included by hrpd_back).
// Each one samples on clk and is disabled while rst_n is low.
`ifndef HISTORY_RUN_PIXEL_DECODER_CORE_ASSERT_SVH
`define HISTORY_RUN_PIXEL_DECODER_CORE_ASSERT_SVH

// Combinational or same-cycle implication.
`define HRPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define HRPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hrpd_pkg.sv
package hrpd_pkg;

    // Pixel and history
    localparam int PIX_W = 16;
    localparam logic [PIX_W-1:0] HIST_RESET = 16'hE003;

    // Run length byte fields
    localparam int LEN_W = 6;
    localparam int RUN_LEN_W = 9;                // up to 255 + 64
    localparam logic [RUN_LEN_W-1:0] EXT_LEN_BASE = 9'h040;
    localparam int NEWEST_PAIR_BIT = 6;
    localparam int PAIR_MODE_BIT = 7;

    // Pixels per token: up to 2 * 319
    localparam int N_W = 10;

    // Image pixel total
    localparam int TOTAL_W = 25;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd65536;

    // Beat shape
    localparam int MAX_PPB = 12;
    localparam int CNT_W = 4;
    localparam int LANE_W = 64;
    localparam int BEAT_W = MAX_PPB * PIX_W;
    localparam int PIXELS_PER_BEAT_DEF = 12;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;

    // Token kinds
    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    // One decoded token ready for beat generation
    typedef struct packed {
        logic [PIX_W-1:0] first_px;
        logic [PIX_W-1:0] second_px;
        logic             pair_mode;
        logic [N_W-1:0]   n_pix;
        logic             image_end;
    } cmd_t;

endpackage

// File: sv/hrpd_front.sv
module hrpd_front
    import hrpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               start_image,
    input  logic               kind,
    input  logic [7:0]         byte_a,
    input  logic [7:0]         byte_b,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOTAL_W-1:0] cfg_data,
    input  logic               q_full,
    output logic               q_wr_en,
    output cmd_t               q_wr_data
);

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] written_reg, written_next;
    logic [PIX_W-1:0]   hist_reg [3];
    logic [PIX_W-1:0]   hist_next [3];

    logic               accept;
    logic [TOTAL_W-1:0] written_eff;
    logic               img_full;
    logic [TOTAL_W-1:0] remaining;
    logic [RUN_LEN_W-1:0] run_len;
    logic [N_W-1:0]     n_raw;
    logic [N_W-1:0]     n_pix;
    logic [PIX_W-1:0]   first_px, second_px;
    logic               pair_mode;

    assign cfg_ready = 1'b1;
    assign full = q_full;
    assign accept = push && !q_full;

    // Token classification and clipping at the image end
    always_comb
    begin
        written_eff = start_image ? '0 : written_reg;
        img_full = (written_eff >= total_reg);
        remaining = total_reg - written_eff;

        if (byte_a[LEN_W-1:0] == '0)
            run_len = {1'b0, byte_b} + EXT_LEN_BASE;
        else
            run_len = RUN_LEN_W'(byte_a[LEN_W-1:0]);

        if (kind == KIND_LITERAL)
        begin
            first_px = {byte_b, byte_a};
            second_px = {byte_b, byte_a};
            pair_mode = 1'b0;
            n_raw = N_W'(1);
        end
        else
        begin
            if (byte_a[NEWEST_PAIR_BIT])
            begin
                first_px = start_image ? HIST_RESET : hist_reg[0];
                second_px = start_image ? HIST_RESET : hist_reg[1];
            end
            else
            begin
                first_px = start_image ? HIST_RESET : hist_reg[1];
                second_px = start_image ? HIST_RESET : hist_reg[2];
            end
            pair_mode = byte_a[PAIR_MODE_BIT];
            n_raw = pair_mode ? {run_len, 1'b0} : {1'b0, run_len};
        end

        if (TOTAL_W'(n_raw) > remaining)
            n_pix = remaining[N_W-1:0];
        else
            n_pix = n_raw;
    end

    // History and pixel count update
    always_comb
    begin
        written_next = written_reg;
        for (int j = 0; j < 3; j++)
            hist_next[j] = hist_reg[j];
        if (accept)
        begin
            if (start_image)
            begin
                written_next = '0;
                for (int j = 0; j < 3; j++)
                    hist_next[j] = HIST_RESET;
            end
            if (!img_full)
            begin
                written_next = written_eff + TOTAL_W'(n_pix);
                if (kind == KIND_LITERAL)
                begin
                    hist_next[2] = start_image ? HIST_RESET : hist_reg[1];
                    hist_next[1] = start_image ? HIST_RESET : hist_reg[0];
                    hist_next[0] = {byte_b, byte_a};
                end
            end
        end
    end

    assign q_wr_en = accept && !img_full;

    always_comb
    begin
        q_wr_data.first_px = first_px;
        q_wr_data.second_px = second_px;
        q_wr_data.pair_mode = pair_mode;
        q_wr_data.n_pix = n_pix;
        q_wr_data.image_end = (TOTAL_W'(n_pix) == remaining);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            written_reg <= '0;
            for (int j = 0; j < 3; j++)
                hist_reg[j] <= HIST_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                total_reg <= cfg_data;
            written_reg <= written_next;
            for (int j = 0; j < 3; j++)
                hist_reg[j] <= hist_next[j];
        end
    end

endmodule

// File: sv/hrpd_cmdq.sv
module hrpd_cmdq
    import hrpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output logic q_empty,
    output cmd_t rd_data
);

    localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    cmd_t            mem_reg [CMD_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign q_full = (count_reg == (AW+1)'(CMD_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !q_full)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en && !q_full)
                wr_ptr_reg <= (wr_ptr_reg == AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en && !q_empty)
                rd_ptr_reg <= (rd_ptr_reg == AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(wr_en && !q_full) - (AW+1)'(rd_en && !q_empty);
        end
    end

endmodule

// File: sv/hrpd_back.sv
module hrpd_back
    import hrpd_pkg::*;
#(
    parameter int PIXELS_PER_BEAT = PIXELS_PER_BEAT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_rd_en,
    input  cmd_t               q_rd_data,
    output logic               empty,
    input  logic               pop,
    output logic [BEAT_W-1:0]  beat_pixels,
    output logic [CNT_W-1:0]   pixel_count,
    output logic               last_beat,
    output logic               image_done
);

`include "history_run_pixel_decoder_core_assert.svh"

    localparam logic [CNT_W-1:0] PPB_C = CNT_W'(PIXELS_PER_BEAT);
    localparam logic PPB_ODD = ((PIXELS_PER_BEAT % 2) == 1);

    cmd_t              cur_reg;
    logic              busy_reg, busy_next;
    logic [N_W-1:0]    rem_reg, rem_next;
    logic              phase_reg, phase_next;

    logic              out_valid_reg, out_valid_next;
    logic [BEAT_W-1:0] pix_reg, pix_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              done_reg, done_next;

    logic              out_free;
    logic              emit;
    logic [CNT_W-1:0]  cnt;
    logic              is_last;
    logic              use_second;

    assign out_free = !out_valid_reg || pop;
    assign q_rd_en = !busy_reg && !q_empty;
    assign emit = busy_reg && out_free;

    // Beat size and pixel slots
    always_comb
    begin
        is_last = (rem_reg <= N_W'(PIXELS_PER_BEAT));
        cnt = is_last ? rem_reg[CNT_W-1:0] : PPB_C;
        for (int k = 0; k < MAX_PPB; k++)
        begin
            use_second = cur_reg.pair_mode && (phase_reg ^ (k % 2 == 1));
            if (CNT_W'(k) < cnt)
                pix_next[k*PIX_W +: PIX_W] = use_second ? cur_reg.second_px
                                                        : cur_reg.first_px;
            else
                pix_next[k*PIX_W +: PIX_W] = '0;
        end
    end

    // Sequencing over one command and the output register
    always_comb
    begin
        busy_next = busy_reg;
        rem_next = rem_reg;
        phase_next = phase_reg;
        out_valid_next = out_valid_reg && !pop;
        cnt_next = cnt_reg;
        last_next = last_reg;
        done_next = done_reg;
        if (q_rd_en)
        begin
            busy_next = 1'b1;
            rem_next = q_rd_data.n_pix;
            phase_next = 1'b0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            cnt_next = cnt;
            last_next = is_last;
            done_next = is_last && cur_reg.image_end;
            rem_next = rem_reg - N_W'(cnt);
            phase_next = phase_reg ^ PPB_ODD;
            if (is_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd_en)
            cur_reg <= q_rd_data;
        if (emit)
            pix_reg <= pix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg <= '0;
            phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg <= rem_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign empty = !out_valid_reg;
    assign beat_pixels = pix_reg;
    assign pixel_count = cnt_reg;
    assign last_beat = last_reg;
    assign image_done = done_reg;

    // Checks
    `HRPD_ASSERT(a_cnt_range, !out_valid_reg || (cnt_reg != '0 && cnt_reg <= PPB_C), "beat count out of range")
    `HRPD_ASSERT(a_done_last, !out_valid_reg || !done_reg || last_reg, "image_done without last_beat")
    `HRPD_ASSERT(a_busy_rem, !busy_reg || rem_reg != '0, "active command with no pixels left")
    `HRPD_ASSERT_NEXT(a_full_beat, emit && !is_last, cnt_reg == PPB_C, "non-final beat not full")

endmodule

// File: sv/history_run_pixel_decoder_core.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+----------------------------------------
// token in  | push / full                   | start_image, kind, byte_a, byte_b
// beat out  | pop / empty                   | pixels_*_four, pixel_count, last_beat,
//           |                               | image_done
// config    | cfg_valid / cfg_ready         | cfg_data (pixel_total)
//
// The front decodes one token per cycle, while full is low, into a two-entry command queue.
// The back loads a command only when idle, then emits beats of up to PIXELS_PER_BEAT pixels,
// one per cycle unless pop stalls them: a literal gives one beat, a run ceil(n/PPB).
// Reset clears the queue, the output register, the history (0xE003 each)
// and the pixel count; pixel_total returns to 65536.
// A stalled pop holds the beat; full rises only when the queue is full.
module history_run_pixel_decoder_core
    import hrpd_pkg::*;
#(
    parameter int PIXELS_PER_BEAT = PIXELS_PER_BEAT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               start_image,
    input  logic               kind,
    input  logic [7:0]         byte_a,
    input  logic [7:0]         byte_b,
    output logic               empty,
    input  logic               pop,
    output logic [LANE_W-1:0]  pixels_first_four,
    output logic [LANE_W-1:0]  pixels_middle_four,
    output logic [LANE_W-1:0]  pixels_final_four,
    output logic [CNT_W-1:0]   pixel_count,
    output logic               last_beat,
    output logic               image_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOTAL_W-1:0] cfg_data
);

    logic              q_full, q_empty, q_wr_en, q_rd_en;
    cmd_t              q_wr_data, q_rd_data;
    logic [BEAT_W-1:0] beat_pixels;

    hrpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .start_image (start_image),
        .kind      (kind),
        .byte_a    (byte_a),
        .byte_b    (byte_b),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    hrpd_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_rd_en),
        .q_empty (q_empty),
        .rd_data (q_rd_data)
    );

    hrpd_back #(
        .PIXELS_PER_BEAT (PIXELS_PER_BEAT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rd_en     (q_rd_en),
        .q_rd_data   (q_rd_data),
        .empty       (empty),
        .pop         (pop),
        .beat_pixels (beat_pixels),
        .pixel_count (pixel_count),
        .last_beat   (last_beat),
        .image_done  (image_done)
    );

    assign pixels_first_four = beat_pixels[LANE_W-1:0];
    assign pixels_middle_four = beat_pixels[2*LANE_W-1:LANE_W];
    assign pixels_final_four = beat_pixels[3*LANE_W-1:2*LANE_W];

endmodule

// File: sim/history_run_pixel_decoder_core_tb.sv
module history_run_pixel_decoder_core_tb;
    import hrpd_pkg::*;

    localparam int PPB           = PIXELS_PER_BEAT_DEF;
    localparam int RANDOM_TOKENS = 500;
    localparam int PHASE_TOKENS  = 85;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 12;
    localparam int TAIL_CYCLES   = 16;
    localparam int QUIET_LIMIT   = 4000;

    // run length byte mode bits
    localparam logic RUN_PAIR    = 1'b1;
    localparam logic RUN_SINGLE  = 1'b0;
    localparam logic PAIR_NEWEST = 1'b1;
    localparam logic PAIR_OLDER  = 1'b0;

    typedef struct {
        logic [LANE_W-1:0] first_four;
        logic [LANE_W-1:0] middle_four;
        logic [LANE_W-1:0] final_four;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              done;
    } beat_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               start_image;
    logic               kind;
    logic [7:0]         byte_a;
    logic [7:0]         byte_b;
    logic               empty;
    logic               pop = 1'b0;
    logic [LANE_W-1:0]  pixels_first_four;
    logic [LANE_W-1:0]  pixels_middle_four;
    logic [LANE_W-1:0]  pixels_final_four;
    logic [CNT_W-1:0]   pixel_count;
    logic               last_beat;
    logic               image_done;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TOTAL_W-1:0] cfg_data;

    // decoder state as the testbench tracks it
    logic [PIX_W-1:0] recent_px [3];
    int               px_written;
    int               image_total;
    beat_t            expected_beats [$];

    int mismatches;
    int beats_checked;
    int tokens_sent;
    int tokens_ignored;
    int productive_tokens;
    int cfg_writes;
    int quiet_cycles;
    int burst_left;
    bit gap_enable;
    int rx_stall_pct;
    int rx_hold;

    history_run_pixel_decoder_core u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .start_image        (start_image),
        .kind               (kind),
        .byte_a             (byte_a),
        .byte_b             (byte_b),
        .empty              (empty),
        .pop                (pop),
        .pixels_first_four  (pixels_first_four),
        .pixels_middle_four (pixels_middle_four),
        .pixels_final_four  (pixels_final_four),
        .pixel_count        (pixel_count),
        .last_beat          (last_beat),
        .image_done         (image_done),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    // Decode one accepted token into its expected beats; returns the beat count
    function automatic int decode_token(input logic st, input logic kd,
                                        input logic [7:0] a, input logic [7:0] b);
        logic [PIX_W-1:0]  px_new;
        logic [PIX_W-1:0]  px_old;
        logic              pair;
        logic [BEAT_W-1:0] lanes;
        beat_t             beat;
        int                len;
        int                n;
        int                sent;
        int                cnt;
        int                beats;
        beats = 0;
        if (st)
        begin
            for (int h = 0; h < 3; h++)
                recent_px[h] = HIST_RESET;
            px_written = 0;
        end
        if (px_written >= image_total)
            return 0;
        if (kd == KIND_LITERAL)
        begin
            recent_px[2] = recent_px[1];
            recent_px[1] = recent_px[0];
            recent_px[0] = {b, a};
            px_new = recent_px[0];
            px_old = px_new;
            pair   = 1'b0;
            n      = 1;
        end
        else
        begin
            len = int'(a[LEN_W-1:0]);
            if (len == 0)
                len = int'(b) + int'(EXT_LEN_BASE);
            if (a[NEWEST_PAIR_BIT])
            begin
                px_new = recent_px[0];
                px_old = recent_px[1];
            end
            else
            begin
                px_new = recent_px[1];
                px_old = recent_px[2];
            end
            pair = a[PAIR_MODE_BIT];
            n    = pair ? 2 * len : len;
        end
        // truncate at the image end
        if (n > image_total - px_written)
            n = image_total - px_written;
        px_written += n;

        sent = 0;
        while (sent < n)
        begin
            cnt   = (n - sent > PPB) ? PPB : n - sent;
            lanes = '0;
            for (int k = 0; k < cnt; k++)
                lanes[PIX_W*k +: PIX_W] = (pair && ((sent + k) % 2 == 1)) ? px_old : px_new;
            sent += cnt;
            beat.first_four  = lanes[0 +: LANE_W];
            beat.middle_four = lanes[LANE_W +: LANE_W];
            beat.final_four  = lanes[2*LANE_W +: LANE_W];
            beat.count       = CNT_W'(cnt);
            beat.last        = (sent >= n);
            beat.done        = (sent >= n) && (px_written >= image_total);
            expected_beats.push_back(beat);
            beats++;
        end
        return beats;
    endfunction

    function automatic logic [7:0] run_byte(input logic pair, input logic newest, input int len);
        logic [7:0] v;
        v = '0;
        v[LEN_W-1:0]      = LEN_W'(len);
        v[NEWEST_PAIR_BIT] = newest;
        v[PAIR_MODE_BIT]   = pair;
        return v;
    endfunction

    // Token transfer: bursts of random length, random gaps between them when gap_enable is set
    task automatic send_token(input logic st, input logic kd,
                              input logic [7:0] a, input logic [7:0] b);
        int gap;
        int beats;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gap_enable ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push        <= 1'b1;
        start_image <= st;
        kind        <= kd;
        byte_a      <= a;
        byte_b      <= b;
        do @(posedge clk); while (full);
        beats = decode_token(st, kd, a, b);
        tokens_sent++;
        if (beats == 0)
            tokens_ignored++;
        else
            productive_tokens++;
    endtask

    task automatic send_random_token(input logic st);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 75)
            len = $urandom_range(1, 12);
        else
            len = $urandom_range(13, 63);
        if ($urandom_range(0, 1))
            send_token(st, KIND_LITERAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
            send_token(st, KIND_RUN,
                       run_byte(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len),
                       8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results();
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Register write only once the decoder has gone quiet
    task automatic write_total(input logic [TOTAL_W-1:0] value);
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        image_total = int'(value);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Runs against the reset history, then literal extremes
    task automatic test_reset_history();
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_NEWEST, 1), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_OLDER, 2), 8'hFF);
        send_token(1'b0, KIND_LITERAL, 8'h00, 8'h00);
        send_token(1'b0, KIND_LITERAL, 8'hFF, 8'hFF);
        send_token(1'b0, KIND_LITERAL, 8'h34, 8'h12);
    endtask

    // Every pair/mode combination, long and extended lengths, image restart
    task automatic test_run_modes();
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_OLDER, 1), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_NEWEST, 1), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 5), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_OLDER, 5), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_OLDER, 63), 8'hFF);
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_OLDER, 0), 8'h00);
        // longest token: pair mode with the largest extension
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 0), 8'hFF);
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_NEWEST, 0), 8'hFF);
        send_token(1'b1, KIND_LITERAL, 8'h5A, 8'hA5);
        send_token(1'b1, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 3), 8'h00);
    endtask

    // Pair run cut mid-pair at the image end; tokens after the end are dropped
    task automatic test_image_end();
        write_total(TOTAL_W'(8));
        send_token(1'b1, KIND_LITERAL, 8'h11, 8'h22);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 2), 8'h00);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 3), 8'h00);
        send_token(1'b0, KIND_LITERAL, 8'h77, 8'h66);
        // dropped literal must not have reached the history
        write_total(TOTAL_W'(12));
        send_token(1'b0, KIND_RUN, run_byte(RUN_SINGLE, PAIR_NEWEST, 2), 8'h00);
    endtask

    task automatic test_total_extremes();
        write_total('0);
        send_token(1'b1, KIND_LITERAL, 8'hAA, 8'h55);
        send_token(1'b0, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 4), 8'h00);
        write_total(TOTAL_W'(1));
        send_token(1'b1, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 63), 8'h00);
        send_token(1'b0, KIND_LITERAL, 8'h01, 8'h80);
        write_total('1);
        send_token(1'b1, KIND_RUN, run_byte(RUN_PAIR, PAIR_NEWEST, 0), 8'hFF);
    endtask

    // Whole images of random tokens over several totals and idle patterns
    task automatic test_random_images();
        logic [TOTAL_W-1:0] phase_total;
        int phase;
        int goal;
        int phase_goal;
        int images;
        int img_tokens;
        int extra;
        logic st;
        goal  = productive_tokens + RANDOM_TOKENS;
        phase = 0;
        while (productive_tokens < goal)
        begin
            case (phase % 6)
                0: phase_total = TOTAL_RESET;
                1: phase_total = TOTAL_W'($urandom_range(2, 64));
                2: phase_total = TOTAL_W'($urandom_range(65, 600));
                3: phase_total = TOTAL_W'(1);
                4: phase_total = '1;
                default: phase_total = TOTAL_W'($urandom_range(2, 20));
            endcase
            case (phase % 3)
                0:
                begin
                    rx_stall_pct = 0;
                    gap_enable = 1'b0;
                end
                1:
                begin
                    rx_stall_pct = 30;
                    gap_enable = 1'b1;
                end
                default:
                begin
                    rx_stall_pct = 70;
                    gap_enable = 1'b1;
                end
            endcase
            write_total(phase_total);
            phase_goal = productive_tokens + PHASE_TOKENS;
            images = 0;
            while (productive_tokens < phase_goal && productive_tokens < goal && images < 30)
            begin
                // one hold-off until the decoder has delivered everything
                if (images == 3)
                begin
                    @(negedge clk);
                    push <= 1'b0;
                    burst_left = 0;
                    wait_results();
                end
                img_tokens = $urandom_range(4, 40);
                for (int t = 0; t < img_tokens; t++)
                begin
                    st = (t == 0) || ($urandom_range(0, 99) < 4);
                    send_random_token(st);
                    if (px_written >= image_total)
                        break;
                end
                // trailing tokens, past the image end when it has been reached
                extra = $urandom_range(0, 2);
                repeat (extra) send_random_token(1'b0);
                images++;
            end
            phase++;
        end
    endtask

    // Beat receiver: stalls in random stretches
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            pop    <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct)
                rx_hold <= $urandom_range(1, 6);
        end
    end

    // Compare each beat transfer with the oldest expectation
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: beat with none expected: count %0d first %h",
                             $realtime, pixel_count, pixels_first_four);
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (want.first_four !== pixels_first_four
                        || want.middle_four !== pixels_middle_four
                        || want.final_four !== pixels_final_four
                        || want.count !== pixel_count
                        || want.last !== last_beat
                        || want.done !== image_done)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: beat %0d mismatch", $realtime, beats_checked);
                        $display("  exp px %h %h %h cnt %0d last %b done %b",
                                 want.final_four, want.middle_four, want.first_four,
                                 want.count, want.last, want.done);
                        $display("  got px %h %h %h cnt %0d last %b done %b",
                                 pixels_final_four, pixels_middle_four, pixels_first_four,
                                 pixel_count, last_beat, image_done);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d beats pending",
                     quiet_cycles, expected_beats.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        start_image  = 1'b0;
        kind         = KIND_LITERAL;
        byte_a       = '0;
        byte_b       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rx_stall_pct = 25;
        rx_hold      = 0;
        gap_enable   = 1'b1;
        burst_left   = 0;
        quiet_cycles = 0;
        image_total  = int'(TOTAL_RESET);
        px_written   = 0;
        for (int h = 0; h < 3; h++)
            recent_px[h] = HIST_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_history();
        test_run_modes();
        test_image_end();
        test_total_extremes();
        test_random_images();

        // drain and let any stray beat show up
        @(negedge clk);
        push <= 1'b0;
        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tokens: %0d sent, %0d dropped past image end; beats checked: %0d",
                 tokens_sent, tokens_ignored, beats_checked);
        $display("pixel_total writes: %0d; mismatches: %0d", cfg_writes, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
